// ----- rtl/mdio_mm_pkg.sv -----
`default_nettype none
package mdio_mm_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int FRAME_BITS    = 32;
  localparam int DIVIDER_BITS  = 6;
  localparam int COUNT_BITS    = $clog2(PREAMBLE_BITS + FRAME_BITS + 1);

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MDC_DIVIDER      = 2'd0,
    CFG_HOLD_CYCLES      = 2'd1,
    CFG_PREAMBLE_DISABLE = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_t;

  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  frame_start;
    logic [1:0]  frame_op;
    logic [4:0]  phy_address;
    logic [4:0]  register_address;
    logic [1:0]  turnaround;
    logic [15:0] write_data;
    logic        mdio_in;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        event_pending;
    logic        busy_res;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
  } out_word_t;

  typedef struct packed {
    logic level;
    logic drive;
  } pin_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0]   frame_shift;
    logic [COUNT_BITS-1:0]   bit_count;
    logic [DIVIDER_BITS-1:0] divide_count;
    logic                    mdc_level;
    logic [2:0]              hold_count;
    logic                    hold_pending;
    logic                    busy_flag;
    logic                    done_flag;
    logic [15:0]             captured_data;
    logic                    read_frame;
    logic                    preamble_on;
    pin_t                    pin;
  } state_t;

  function automatic logic [COUNT_BITS-1:0] pre_len(input logic preamble_on);
    pre_len = preamble_on ? COUNT_BITS'(PREAMBLE_BITS) : '0;
  endfunction

  function automatic logic [COUNT_BITS-1:0] frame_len(input logic preamble_on);
    frame_len = COUNT_BITS'(FRAME_BITS) + pre_len(preamble_on);
  endfunction

  // level and drive for the bit now on the line
  function automatic pin_t present_bit(input logic [COUNT_BITS-1:0] bc,
                                       input logic                  preamble_on,
                                       input logic                  rd,
                                       input logic [FRAME_BITS-1:0] fs);
    logic [COUNT_BITS-1:0] diff;
    logic [4:0]            j;
    pin_t                  r;
    diff = bc - pre_len(preamble_on);
    j    = diff[4:0];
    if (bc >= frame_len(preamble_on)) begin
      r = '0;
    end else if (bc < pre_len(preamble_on)) begin
      r = '{level: 1'b1, drive: 1'b1};
    end else if (rd && (j >= 5'd14)) begin
      r = '0;
    end else begin
      r = '{level: fs[5'd31 - j], drive: 1'b1};
    end
    present_bit = r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mdio_management_master.sv -----
`default_nettype none
// Clause 22 MDIO management master driven by a stream of words: each input word is
// one clock tick, a frame register write, an event clear or a status read, and
// gives exactly one result word with the data field, event and busy flags and the
// MDC/MDIO pin levels after that word. Each word is worked out in the cycle it is
// accepted, and its result is presented from a single result register the cycle
// after acceptance. A new word is taken every cycle as long as the result register
// is empty or is being read in that same cycle; while a result waits for out_ready
// the input stalls. Configuration writes are always accepted (cfg_ready is tied
// high) and belong between words, with nothing in flight.
module mdio_management_master (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mdio_mm_pkg::in_word_t          in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mdio_mm_pkg::out_word_t              out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [mdio_mm_pkg::DIVIDER_BITS-1:0] cfg_data
);

  logic [mdio_mm_pkg::DIVIDER_BITS-1:0] mdc_divider_r;
  logic [2:0]                           hold_cycles_r;
  logic                                 preamble_disable_r;

  mdio_mm_pkg::state_t    st_r, st_nxt;
  mdio_mm_pkg::out_word_t out_r, out_nxt;
  logic                   out_valid_r;
  logic                   in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mdc_divider_r      <= '0;
      hold_cycles_r      <= '0;
      preamble_disable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mdio_mm_pkg::cfg_index_t'(cfg_index))
        mdio_mm_pkg::CFG_MDC_DIVIDER:      mdc_divider_r      <= cfg_data;
        mdio_mm_pkg::CFG_HOLD_CYCLES:      hold_cycles_r      <= cfg_data[2:0];
        mdio_mm_pkg::CFG_PREAMBLE_DISABLE: preamble_disable_r <= cfg_data[0];
        mdio_mm_pkg::CFG_UNUSED: ;
      endcase
    end
  end

  always_comb begin
    logic [mdio_mm_pkg::COUNT_BITS-1:0] flen;
    logic [mdio_mm_pkg::COUNT_BITS-1:0] plen;
    st_nxt = st_r;
    flen   = mdio_mm_pkg::frame_len(st_r.preamble_on);
    plen   = mdio_mm_pkg::pre_len(st_r.preamble_on);
    unique case (in_data.mode)
      mdio_mm_pkg::MODE_TICK: begin
        if ((mdc_divider_r != '0) && st_r.busy_flag) begin
          if (st_r.hold_pending) begin
            if (st_r.hold_count == '0) begin
              st_nxt.hold_pending = 1'b0;
              st_nxt.pin = mdio_mm_pkg::present_bit(st_r.bit_count, st_r.preamble_on,
                                                    st_r.read_frame, st_r.frame_shift);
            end else begin
              st_nxt.hold_count = st_r.hold_count - 3'd1;
            end
          end
          if (st_r.divide_count >= mdc_divider_r) begin
            st_nxt.divide_count = '0;
            st_nxt.mdc_level    = !st_r.mdc_level;
            if (!st_r.mdc_level) begin
              // rising edge: sample read data
              if (st_r.read_frame &&
                  (st_r.bit_count >= plen + mdio_mm_pkg::COUNT_BITS'(16)) &&
                  (st_r.bit_count < flen)) begin
                st_nxt.captured_data = {st_r.captured_data[14:0], in_data.mdio_in};
              end
            end else begin
              st_nxt.bit_count = st_r.bit_count + mdio_mm_pkg::COUNT_BITS'(1);
              if (st_nxt.bit_count >= flen) begin
                st_nxt.busy_flag    = 1'b0;
                st_nxt.done_flag    = 1'b1;
                st_nxt.hold_pending = 1'b0;
                st_nxt.hold_count   = '0;
                st_nxt.pin          = '0;
              end else begin
                st_nxt.hold_pending = 1'b1;
                st_nxt.hold_count   = hold_cycles_r;
              end
            end
          end else begin
            st_nxt.divide_count = st_r.divide_count + mdio_mm_pkg::DIVIDER_BITS'(1);
          end
        end
      end
      mdio_mm_pkg::MODE_WRITE: begin
        if (!st_r.busy_flag) begin
          st_nxt.frame_shift   = {in_data.frame_start, in_data.frame_op, in_data.phy_address,
                                  in_data.register_address, in_data.turnaround,
                                  in_data.write_data};
          st_nxt.read_frame    = (in_data.frame_op == mdio_mm_pkg::OP_READ);
          st_nxt.captured_data = in_data.write_data;
          st_nxt.preamble_on   = !preamble_disable_r;
          st_nxt.bit_count     = '0;
          st_nxt.divide_count  = '0;
          st_nxt.mdc_level     = 1'b0;
          st_nxt.hold_pending  = 1'b0;
          st_nxt.hold_count    = '0;
          st_nxt.busy_flag     = 1'b1;
          st_nxt.pin = mdio_mm_pkg::present_bit('0, st_nxt.preamble_on,
                                                st_nxt.read_frame, st_nxt.frame_shift);
        end
      end
      mdio_mm_pkg::MODE_CLEAR: begin
        st_nxt.done_flag = 1'b0;
      end
      mdio_mm_pkg::MODE_STATUS: ;
    endcase

    out_nxt.read_data     = st_nxt.captured_data;
    out_nxt.event_pending = st_nxt.done_flag;
    out_nxt.busy_res      = st_nxt.busy_flag;
    out_nxt.mdc           = st_nxt.mdc_level;
    out_nxt.mdio_out      = st_nxt.pin.drive & st_nxt.pin.level;
    out_nxt.mdio_drive    = st_nxt.pin.drive;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.busy_flag |-> !st_r.pin.drive)
    else $error("mdio driven while no frame in progress");

  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.busy_flag |-> (st_r.bit_count < mdio_mm_pkg::frame_len(st_r.preamble_on)))
    else $error("bit count beyond frame length while busy");

  a_hold_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hold_pending |-> st_r.busy_flag)
    else $error("hold pending outside a frame");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.mode == mdio_mm_pkg::MODE_WRITE) && !st_r.busy_flag)
      |=> (st_r.busy_flag && out_valid_r && out_r.busy_res))
    else $error("frame write did not start a frame");

endmodule
`default_nettype wire
